/* rtl/pce_pkg.sv */
// ----------------------------------------------------------------------------
// pce_pkg
// Types, codes and helper functions shared by the path command encoder.
// ----------------------------------------------------------------------------
package pce_pkg;

    localparam int COORD_W     = 32;
    localparam int WORD_W      = 32;
    localparam int CNT_FIELD_W = 28;
    localparam int COUNT_BITS  = 28;
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_IDX_W  = $clog2(MAX_RESULTS);
    localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        CMD_MOVE   = 3'd0,
        CMD_LINE   = 3'd1,
        CMD_BEZIER = 3'd2,
        CMD_CLOSE  = 3'd3,
        CMD_REPORT = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_op_t;

    typedef enum logic [1:0] {
        SEG_NONE   = 2'd0,
        SEG_LINE   = 2'd1,
        SEG_BEZIER = 2'd2
    } seg_t;

    typedef enum logic [1:0] {
        KIND_WORD      = 2'd0,
        KIND_POINT     = 2'd1,
        KIND_OVERWRITE = 2'd2,
        KIND_REPORT    = 2'd3
    } kind_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Command transfer
    typedef struct packed {
        logic [2:0] op;
        coord_t     x0;
        coord_t     y0;
        coord_t     x1;
        coord_t     y1;
        coord_t     x2;
        coord_t     y2;
    } cmd_t;

    // Result transfer
    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] op_word;
        coord_t            px;
        coord_t            py;
        coord_t            box_left;
        coord_t            box_top;
        coord_t            box_right;
        coord_t            box_bottom;
        logic              box_valid;
        logic              last;
    } res_t;

    // Op word under construction
    typedef struct packed {
        logic                  mv;
        logic                  cl;
        seg_t                  seg_type;
        logic [COUNT_BITS-1:0] count;
    } open_t;

    typedef struct packed {
        logic   valid;
        coord_t min_x;
        coord_t min_y;
        coord_t max_x;
        coord_t max_y;
    } box_t;

    typedef struct packed {
        logic   valid;
        coord_t x;
        coord_t y;
    } pend_t;

    // One result of an item, without the box
    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] op_word;
        coord_t            px;
        coord_t            py;
    } slot_t;

    // All results of one item
    typedef struct packed {
        logic [NUM_W-1:0]              num;
        slot_t [MAX_RESULTS-1:0]       slots;
        box_t                          box;
    } batch_t;

    function automatic logic [WORD_W-1:0] open_word(input open_t o);
        return {o.mv, o.cl, o.seg_type, CNT_FIELD_W'(o.count)};
    endfunction

    function automatic box_t point_box(input logic valid, input coord_t x, input coord_t y);
        box_t b;
        b = '0;
        if (valid)
        begin
            b.valid = 1'b1;
            b.min_x = x;
            b.max_x = x;
            b.min_y = y;
            b.max_y = y;
        end
        return b;
    endfunction

    function automatic box_t box_merge(input box_t a, input box_t b);
        box_t r;
        if (!a.valid)
        begin
            r = b;
        end
        else if (!b.valid)
        begin
            r = a;
        end
        else
        begin
            r.valid = 1'b1;
            r.min_x = ($signed(b.min_x) < $signed(a.min_x)) ? b.min_x : a.min_x;
            r.min_y = ($signed(b.min_y) < $signed(a.min_y)) ? b.min_y : a.min_y;
            r.max_x = ($signed(a.max_x) < $signed(b.max_x)) ? b.max_x : a.max_x;
            r.max_y = ($signed(a.max_y) < $signed(b.max_y)) ? b.max_y : a.max_y;
        end
        return r;
    endfunction

endpackage

/* rtl/pce_core.sv */
// ----------------------------------------------------------------------------
// pce_core
// Path state (open op word, bounding box, pending move point) and the
// single-pass logic that turns one command into its batch of results.
// ----------------------------------------------------------------------------
module pce_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  pce_pkg::cmd_t   item,
    output pce_pkg::batch_t batch
);

    pce_pkg::open_t open_reg, open_next, seg_base;
    pce_pkg::box_t  box_reg, box_next;
    pce_pkg::pend_t pend_reg, pend_next;

    pce_pkg::box_t  pend_box, rep_box, p0_box, p1_box, p2_box, seg_box;
    pce_pkg::slot_t word_slot, pt0_slot, pt1_slot, pt2_slot;
    pce_pkg::seg_t  seg_sel;
    logic           is_bez;
    logic [1:0]     npts;
    logic           seg_flush;

    // Decode segment flavour
    assign is_bez  = (item.op == pce_pkg::CMD_BEZIER);
    assign seg_sel = is_bez ? pce_pkg::SEG_BEZIER : pce_pkg::SEG_LINE;
    assign npts    = is_bez ? 2'd3 : 2'd1;

    // Close the open run on a type change or a count that would overflow
    assign seg_flush =
        ((open_reg.seg_type != pce_pkg::SEG_NONE) && (open_reg.seg_type != seg_sel))
        || ((open_reg.seg_type == seg_sel)
            && (open_reg.count > (pce_pkg::CNT_MAX - pce_pkg::COUNT_BITS'(npts))));

    // Bounding box tree: committed box, pending move, then new points
    assign pend_box = pce_pkg::point_box(pend_reg.valid, pend_reg.x, pend_reg.y);
    assign rep_box  = pce_pkg::box_merge(box_reg, pend_box);
    assign p0_box   = pce_pkg::point_box(1'b1, item.x0, item.y0);
    assign p1_box   = pce_pkg::point_box(is_bez, item.x1, item.y1);
    assign p2_box   = pce_pkg::point_box(is_bez, item.x2, item.y2);
    assign seg_box  = pce_pkg::box_merge(
                          pce_pkg::box_merge(rep_box, pce_pkg::box_merge(p0_box, p1_box)),
                          p2_box);

    // Result slot templates
    assign word_slot = '{kind: pce_pkg::KIND_WORD, op_word: pce_pkg::open_word(open_reg),
                         px: '0, py: '0};
    assign pt0_slot  = '{kind: pce_pkg::KIND_POINT, op_word: '0, px: item.x0, py: item.y0};
    assign pt1_slot  = '{kind: pce_pkg::KIND_POINT, op_word: '0, px: item.x1, py: item.y1};
    assign pt2_slot  = '{kind: pce_pkg::KIND_POINT, op_word: '0, px: item.x2, py: item.y2};
    assign seg_base  = seg_flush ? '0 : open_reg;

    // Build the batch and next state for this command
    always_comb
    begin
        open_next = open_reg;
        box_next  = box_reg;
        pend_next = pend_reg;
        batch     = '0;
        unique case (pce_pkg::cmd_op_t'(item.op)) inside
            pce_pkg::CMD_MOVE:
            begin
                if (open_reg.seg_type != pce_pkg::SEG_NONE)
                begin
                    batch.slots[0] = word_slot;
                    batch.slots[1] = pt0_slot;
                    batch.num      = pce_pkg::NUM_W'(2);
                    open_next      = '0;
                    open_next.mv   = 1'b1;
                end
                else if (open_reg.mv)
                begin
                    batch.slots[0]      = pt0_slot;
                    batch.slots[0].kind = pce_pkg::KIND_OVERWRITE;
                    batch.num           = pce_pkg::NUM_W'(1);
                end
                else
                begin
                    batch.slots[0] = pt0_slot;
                    batch.num      = pce_pkg::NUM_W'(1);
                    open_next.mv   = 1'b1;
                end
                pend_next = '{valid: 1'b1, x: item.x0, y: item.y0};
            end
            pce_pkg::CMD_LINE, pce_pkg::CMD_BEZIER:
            begin
                if (seg_flush)
                begin
                    batch.slots[0] = word_slot;
                    batch.slots[1] = pt0_slot;
                    batch.slots[2] = pt1_slot;
                    batch.slots[3] = pt2_slot;
                    batch.num      = pce_pkg::NUM_W'(npts) + pce_pkg::NUM_W'(1);
                end
                else
                begin
                    batch.slots[0] = pt0_slot;
                    batch.slots[1] = pt1_slot;
                    batch.slots[2] = pt2_slot;
                    batch.num      = pce_pkg::NUM_W'(npts);
                end
                open_next.mv       = seg_base.mv;
                open_next.cl       = seg_base.cl;
                open_next.seg_type = seg_sel;
                open_next.count    = seg_base.count + pce_pkg::COUNT_BITS'(npts);
                box_next           = seg_box;
                pend_next.valid    = 1'b0;
            end
            pce_pkg::CMD_CLOSE:
            begin
                if (open_reg.seg_type != pce_pkg::SEG_NONE)
                begin
                    batch.slots[0] = word_slot;
                    batch.num      = pce_pkg::NUM_W'(1);
                    open_next      = '0;
                    open_next.cl   = 1'b1;
                end
            end
            pce_pkg::CMD_REPORT:
            begin
                batch.slots[0]      = word_slot;
                batch.slots[0].kind = pce_pkg::KIND_REPORT;
                batch.num           = pce_pkg::NUM_W'(1);
                batch.box           = rep_box;
            end
            pce_pkg::CMD_CLEAR:
            begin
                open_next = '0;
                box_next  = '0;
                pend_next = '0;
            end
            default:
            begin
                // unused codes: drop the command
            end
        endcase
    end

    // Update path state on each transfer into the core
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
            box_reg  <= '0;
            pend_reg <= '0;
        end
        else if (take)
        begin
            open_reg <= open_next;
            box_reg  <= box_next;
            pend_reg <= pend_next;
        end
    end

    // An open op with no segment type carries no count
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg.seg_type == pce_pkg::SEG_NONE) |-> (open_reg.count == '0))
        else $error("open op has a count but no segment type");

    // A pending move point only exists while a bare move is open
    a_pend_move: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg.valid |-> (open_reg.mv && (open_reg.seg_type == pce_pkg::SEG_NONE)))
        else $error("pending point without an open bare move");

endmodule

/* rtl/pce_serializer.sv */
// ----------------------------------------------------------------------------
// pce_serializer
// Holds the result batch of one command and hands its results out one per
// transfer, marking the final one.
// ----------------------------------------------------------------------------
module pce_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  pce_pkg::batch_t batch_in,
    output logic            ready,
    output logic            res_valid,
    input  logic            res_stall,
    output pce_pkg::res_t   res
);

    logic                            busy_reg, busy_next;
    logic [pce_pkg::SLOT_IDX_W-1:0]  idx_reg, idx_next;
    logic [pce_pkg::NUM_W-1:0]       num_reg;
    pce_pkg::slot_t [pce_pkg::MAX_RESULTS-1:0] slots_reg;
    pce_pkg::box_t                   box_reg;
    pce_pkg::slot_t                  sel;
    logic                            take;
    logic                            at_last;

    assign take    = busy_reg && !res_stall;
    assign at_last = ((pce_pkg::NUM_W'(idx_reg) + pce_pkg::NUM_W'(1)) == num_reg);
    assign ready   = !busy_reg || (take && at_last);

    // Advance through the batch, reload when the last result leaves
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load && (batch_in.num != '0))
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (ready)
        begin
            busy_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + pce_pkg::SLOT_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Capture the batch payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg   <= batch_in.num;
            slots_reg <= batch_in.slots;
            box_reg   <= batch_in.box;
        end
    end

    // Drive the current result
    assign sel       = slots_reg[idx_reg];
    assign res_valid = busy_reg;

    always_comb
    begin
        res            = '0;
        res.kind       = sel.kind;
        res.op_word    = sel.op_word;
        res.px         = sel.px;
        res.py         = sel.py;
        res.last       = at_last;
        res.box_valid  = box_reg.valid;
        if (box_reg.valid)
        begin
            res.box_left   = box_reg.min_x;
            res.box_top    = box_reg.min_y;
            res.box_right  = box_reg.max_x;
            res.box_bottom = box_reg.max_y;
        end
    end

    // A held batch has between one and four results
    a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((num_reg != '0) && (num_reg <= pce_pkg::NUM_W'(pce_pkg::MAX_RESULTS))))
        else $error("batch result count out of range");

    // The read index stays inside the batch
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pce_pkg::NUM_W'(idx_reg) < num_reg))
        else $error("result index past end of batch");

    // A stalled result keeps its place in the batch
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && res_stall) |=> (busy_reg && $stable(idx_reg)))
        else $error("batch moved on while output stalled");

endmodule

/* rtl/path_command_encoder.sv */
// ----------------------------------------------------------------------------
// path_command_encoder
// Packs vector path commands into op words and points, keeping a bounding box.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one path command per
//   transfer: move, line, cubic bezier, close, report or clear.
//   res channel (res_valid / res_stall / res) carries the results of each
//   command in order, one per transfer, with res.last on the final one.
//   A command that causes no result (clear, close with no open run, an
//   unused code) leaves nothing on res; of these only clear changes state.
// Flow: a command is held in the input register until the serializer is
//   free, then its batch is registered in the serializer.
// Throughput: one result per cycle out of the serializer while res_stall
//   is low; a new batch loads as the last result of the previous leaves.
//   A command has one result for most commands, two for a move after a
//   run, up to four for a bezier that closes the open run.
// Reset: rst_n clears the open op word, the box and the pending move point;
//   no results are held afterwards.
// Stall: while res_stall is high the current result holds; one further
//   command waits in the input register and cmd_stall rises behind it.
// ----------------------------------------------------------------------------
module path_command_encoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  pce_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output pce_pkg::res_t res
);

    logic            item_valid_reg;
    pce_pkg::cmd_t   item_reg;
    logic            ser_ready;
    logic            core_take;
    pce_pkg::batch_t batch;

    assign core_take = item_valid_reg && ser_ready;
    assign cmd_stall = item_valid_reg && !ser_ready;

    // Input register: take a command whenever the held one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            item_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            item_reg <= cmd;
        end
    end

    pce_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (core_take),
        .item  (item_reg),
        .batch (batch)
    );

    pce_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (core_take),
        .batch_in  (batch),
        .ready     (ser_ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
